// ===== hdl/readout_chip_frame_decoder_assert.svh =====
// Assertion macros shared by the readout frame decoder checkers.
// Depends on nothing; included by the checker file.
`ifndef READOUT_CHIP_FRAME_DECODER_ASSERT_SVH
`define READOUT_CHIP_FRAME_DECODER_ASSERT_SVH

// same-cycle implication under reset
`define RCFD_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("rcfd assertion failed");

// next-cycle implication under reset
`define RCFD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("rcfd assertion failed");

`endif

// ===== hdl/rcfd_pkg.sv =====
// Shared types, constants and helper functions of the readout frame decoder.
// Depends on nothing; imported by the front, queue, back and top-level modules.
`default_nettype none

package rcfd_pkg;

  localparam int unsigned FRAME_WORDS = 11;
  localparam int unsigned POS_W       = $clog2(FRAME_WORDS + 1);

  localparam logic [POS_W-1:0] POS_HEADER = POS_W'(0);
  localparam logic [POS_W-1:0] POS_STUB   = POS_W'(1);
  localparam logic [POS_W-1:0] POS_STATUS = POS_W'(2);
  localparam logic [POS_W-1:0] POS_LAST   = POS_W'(FRAME_WORDS - 1);
  localparam logic [POS_W-1:0] POS_IDLE   = POS_W'(FRAME_WORDS);

  // header check
  localparam logic [11:0] DATA_SIZE = 12'd10;

  // channel bits inside word 2 and the last word
  localparam logic [31:0] HIT_MASK_STATUS = 32'hF000_0000;
  localparam logic [31:0] HIT_MASK_LAST   = 32'h03FF_FFFF;

  // configuration port
  localparam int unsigned ADDR_W       = 3;
  localparam logic        REG_EXP_BOARD = 1'b0;

  // summary queue between front and back
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [7:0]  hits;
    logic [31:0] stub_word;
    logic [31:0] status_word;
    logic [3:0]  hdr_flags;
  } frame_rec_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef struct packed {
    logic [7:0] position;
    logic [3:0] bend;
  } stub_t;

  function automatic logic [2:0] pop4(input logic [3:0] v);
    pop4 = 3'(v[0]) + 3'(v[1]) + 3'(v[2]) + 3'(v[3]);
  endfunction

  function automatic logic [5:0] popcnt32(input logic [31:0] v);
    logic [5:0] s;
    s = '0;
    for (int i = 0; i < 8; i++) begin
      s = s + 6'(pop4(v[4*i +: 4]));
    end
    popcnt32 = s;
  endfunction

  function automatic logic [8:0] rev9(input logic [8:0] v);
    logic [8:0] r;
    for (int i = 0; i < 9; i++) begin
      r[i] = v[8-i];
    end
    rev9 = r;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/rcfd_front.sv =====
// Front end: takes frame words, tracks the word position, checks the header
// and accumulates the hit count. Pushes one frame record at the last word. Uses rcfd_pkg.
`default_nettype none

module rcfd_front (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic [31:0]         data_word_i,
  input  wire logic                frame_start_i,
  input  wire logic [2:0]          fe_index_i,
  input  wire logic [4:0]          chip_index_i,
  input  wire logic                push_i,
  output logic                     full_o,
  input  wire logic [4:0]          exp_board_i,
  input  wire rcfd_pkg::q_stat_t   q_stat_i,
  output logic                     q_push_o,
  output rcfd_pkg::frame_rec_t     q_rec_o
);
  import rcfd_pkg::*;

  logic [POS_W-1:0] word_pos_q, word_pos_d, pos;
  logic [7:0]       hit_q, hit_d, hit_sum;
  logic [31:0]      stub_q, status_q;
  logic [3:0]       hdr_q, hdr_d;
  logic [31:0]      hit_bits;
  logic             beat, live;

  assign full_o = q_stat_i.full;
  assign beat   = push_i && !q_stat_i.full;
  assign pos    = frame_start_i ? POS_HEADER : word_pos_q;
  assign live   = beat && (pos < POS_IDLE);

  always_comb begin
    case (pos)
      POS_HEADER, POS_STUB: hit_bits = '0;
      POS_STATUS:           hit_bits = data_word_i & HIT_MASK_STATUS;
      POS_LAST:             hit_bits = data_word_i & HIT_MASK_LAST;
      default:              hit_bits = data_word_i;
    endcase
  end

  assign hit_sum = hit_q + 8'(popcnt32(hit_bits));

  always_comb begin
    hdr_d[0] = {1'b0, data_word_i[24:20]} != (6'(exp_board_i) + 6'd1);
    hdr_d[1] = {1'b0, data_word_i[19:17]} != (4'(fe_index_i) + 4'd1);
    hdr_d[2] = {1'b0, data_word_i[16:12]} != (6'(chip_index_i) + 6'd1);
    hdr_d[3] = data_word_i[11:0] != DATA_SIZE;
  end

  always_comb begin
    word_pos_d = word_pos_q;
    hit_d      = hit_q;
    if (live) begin
      word_pos_d = pos + POS_W'(1);
      hit_d      = (pos == POS_HEADER) ? 8'd0 : hit_sum;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word_pos_q <= POS_HEADER;
    end else begin
      word_pos_q <= word_pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hit_q <= hit_d;
    if (live && pos == POS_HEADER) begin
      hdr_q <= hdr_d;
    end
    if (live && pos == POS_STUB) begin
      stub_q <= data_word_i;
    end
    if (live && pos == POS_STATUS) begin
      status_q <= data_word_i;
    end
  end

  assign q_push_o              = live && (pos == POS_LAST);
  assign q_rec_o.hits          = hit_sum;
  assign q_rec_o.stub_word     = stub_q;
  assign q_rec_o.status_word   = status_q;
  assign q_rec_o.hdr_flags     = hdr_q;

endmodule

`default_nettype wire

// ===== hdl/rcfd_queue.sv =====
// Short queue of frame records between the front and back ends.
// Uses rcfd_pkg for the record type and depth.
`default_nettype none

module rcfd_queue (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 push_i,
  input  wire rcfd_pkg::frame_rec_t rec_i,
  input  wire logic                 pop_i,
  output rcfd_pkg::frame_rec_t      rec_o,
  output rcfd_pkg::q_stat_t         stat_o
);
  import rcfd_pkg::*;

  frame_rec_t        slot_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_q, rd_q;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic              do_push, do_pop;

  assign stat_o.full  = cnt_q == QCNT_W'(QUEUE_DEPTH);
  assign stat_o.empty = cnt_q == '0;
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign rec_o        = slot_q[rd_q];

  always_comb begin
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + QCNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (do_push) begin
        wr_q <= wr_q + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_q <= rd_q + QPTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_q] <= rec_i;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/rcfd_back.sv =====
// Back end: unpacks a frame record into the summary (stub packing, bit
// reversal, flags) and holds it in the output register. Uses rcfd_pkg.
`default_nettype none

module rcfd_back (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire rcfd_pkg::q_stat_t    q_stat_i,
  input  wire rcfd_pkg::frame_rec_t q_rec_i,
  output logic                      q_pop_o,
  output logic                      empty_o,
  input  wire logic                 pop_i,
  output logic [7:0]                hit_count_o,
  output logic [1:0]                stub_count_o,
  output rcfd_pkg::stub_t           stub0_o,
  output rcfd_pkg::stub_t           stub1_o,
  output rcfd_pkg::stub_t           stub2_o,
  output logic [1:0]                error_bits_o,
  output logic [8:0]                pipeline_address_o,
  output logic [8:0]                l1a_count_o,
  output logic [4:0]                check_flags_o
);
  import rcfd_pkg::*;

  logic        valid_q;
  stub_t       s0, s1, s2, p0, p1, p2;
  logic [2:0]  v;
  logic [1:0]  cnt;

  assign empty_o = !valid_q;
  assign q_pop_o = !q_stat_i.empty && (!valid_q || pop_i);

  always_comb begin
    s0 = '{position: q_rec_i.stub_word[7:0],   bend: q_rec_i.stub_word[27:24]};
    s1 = '{position: q_rec_i.stub_word[15:8],  bend: q_rec_i.stub_word[31:28]};
    s2 = '{position: q_rec_i.stub_word[23:16], bend: q_rec_i.status_word[3:0]};
    v[0] = (s0.position != '0) && (s0.bend != '0);
    v[1] = (s1.position != '0) && (s1.bend != '0);
    v[2] = (s2.position != '0) && (s2.bend != '0);
    cnt  = 2'(v[0]) + 2'(v[1]) + 2'(v[2]);

    if (v[0])      p0 = s0;
    else if (v[1]) p0 = s1;
    else if (v[2]) p0 = s2;
    else           p0 = '0;

    if (v[0] && v[1])              p1 = s1;
    else if ((v[0] ^ v[1]) && v[2]) p1 = s2;
    else                           p1 = '0;

    p2 = (&v) ? s2 : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (q_pop_o) begin
      valid_q <= 1'b1;
    end else if (pop_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      hit_count_o        <= q_rec_i.hits;
      stub_count_o       <= cnt;
      stub0_o            <= p0;
      stub1_o            <= p1;
      stub2_o            <= p2;
      error_bits_o       <= {q_rec_i.status_word[8], q_rec_i.status_word[9]};
      pipeline_address_o <= rev9(q_rec_i.status_word[18:10]);
      l1a_count_o        <= rev9(q_rec_i.status_word[27:19]);
      check_flags_o      <= {~q_rec_i.status_word[7], q_rec_i.hdr_flags};
    end
  end

endmodule

`default_nettype wire

// ===== hdl/readout_chip_frame_decoder.sv =====
// Readout chip frame decoder: takes one 32-bit frame word per clock while full is low,
// and gives one summary per eleven-word frame. The front end processes each word in the
// cycle it is accepted (one 32-bit popcount and 8-bit add is the longest path);
// at the last word it pushes a record into a four-deep queue, and the back end
// turns the oldest record into the result register whenever that register is empty
// or being popped. Words are taken when push is high and full is low; full is raised
// only while four frame records wait behind an unread result.
// A word with frame_start set always starts a new frame; words after the last
// one of a frame and before the next frame_start produce nothing.
// expected_board_id lives at byte address 0 of the APB port.
`default_nettype none

module readout_chip_frame_decoder (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [rcfd_pkg::ADDR_W-1:0] paddr,
  input  wire logic [31:0]                 pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready,
  input  wire logic [31:0]                 data_word_i,
  input  wire logic                        frame_start_i,
  input  wire logic [2:0]                  fe_index_i,
  input  wire logic [4:0]                  chip_index_i,
  input  wire logic                        push_i,
  output logic                             full_o,
  output logic                             empty_o,
  input  wire logic                        pop_i,
  output logic [7:0]                       hit_count_o,
  output logic [1:0]                       stub_count_o,
  output logic [7:0]                       stub0_position_o,
  output logic [3:0]                       stub0_bend_o,
  output logic [7:0]                       stub1_position_o,
  output logic [3:0]                       stub1_bend_o,
  output logic [7:0]                       stub2_position_o,
  output logic [3:0]                       stub2_bend_o,
  output logic [1:0]                       error_bits_o,
  output logic [8:0]                       pipeline_address_o,
  output logic [8:0]                       l1a_count_o,
  output logic [4:0]                       check_flags_o
);
  import rcfd_pkg::*;

  logic [4:0] exp_board_q;
  logic       q_push, q_pop;
  frame_rec_t q_wr_rec, q_rd_rec;
  q_stat_t    q_stat;
  stub_t      stub0, stub1, stub2;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_EXP_BOARD) ? {27'd0, exp_board_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_board_q <= '0;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_EXP_BOARD) begin
      exp_board_q <= pwdata[4:0];
    end
  end

  rcfd_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .data_word_i   (data_word_i),
    .frame_start_i (frame_start_i),
    .fe_index_i    (fe_index_i),
    .chip_index_i  (chip_index_i),
    .push_i        (push_i),
    .full_o        (full_o),
    .exp_board_i   (exp_board_q),
    .q_stat_i      (q_stat),
    .q_push_o      (q_push),
    .q_rec_o       (q_wr_rec)
  );

  rcfd_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .rec_i  (q_wr_rec),
    .pop_i  (q_pop),
    .rec_o  (q_rd_rec),
    .stat_o (q_stat)
  );

  rcfd_back u_back (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .q_stat_i           (q_stat),
    .q_rec_i            (q_rd_rec),
    .q_pop_o            (q_pop),
    .empty_o            (empty_o),
    .pop_i              (pop_i),
    .hit_count_o        (hit_count_o),
    .stub_count_o       (stub_count_o),
    .stub0_o            (stub0),
    .stub1_o            (stub1),
    .stub2_o            (stub2),
    .error_bits_o       (error_bits_o),
    .pipeline_address_o (pipeline_address_o),
    .l1a_count_o        (l1a_count_o),
    .check_flags_o      (check_flags_o)
  );

  assign stub0_position_o = stub0.position;
  assign stub0_bend_o     = stub0.bend;
  assign stub1_position_o = stub1.position;
  assign stub1_bend_o     = stub1.bend;
  assign stub2_position_o = stub2.position;
  assign stub2_bend_o     = stub2.bend;

endmodule

`default_nettype wire

// ===== hdl/rcfd_checker.sv =====
// Port-level checks of the readout frame decoder, bound to the top level.
// Depends on readout_chip_frame_decoder_assert.svh.
`default_nettype none

`include "readout_chip_frame_decoder_assert.svh"

module rcfd_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       empty_o,
  input wire logic       pop_i,
  input wire logic [7:0] hit_count_o,
  input wire logic [1:0] stub_count_o,
  input wire logic [7:0] stub0_position_o,
  input wire logic [3:0] stub0_bend_o,
  input wire logic [7:0] stub1_position_o,
  input wire logic [3:0] stub1_bend_o,
  input wire logic [7:0] stub2_position_o,
  input wire logic [3:0] stub2_bend_o,
  input wire logic [4:0] check_flags_o
);

  // a waiting beat holds until popped
  `RCFD_ASSERT_NEXT(a_hold, clk_i, rst_ni, !empty_o && !pop_i, !empty_o && $stable(hit_count_o) && $stable(check_flags_o))

  // 254 channel bits at most
  `RCFD_ASSERT_IMPLY(a_hits, clk_i, rst_ni, !empty_o, hit_count_o != 8'hFF)

  // slot 0 holds a valid stub whenever any stub is counted
  `RCFD_ASSERT_IMPLY(a_slot0, clk_i, rst_ni, !empty_o && stub_count_o != 2'd0, stub0_position_o != 8'd0 && stub0_bend_o != 4'd0)

  // unused slots read as zero
  `RCFD_ASSERT_IMPLY(a_slot1, clk_i, rst_ni, !empty_o && (stub_count_o == 2'd0 || stub_count_o == 2'd1), stub1_position_o == 8'd0 && stub1_bend_o == 4'd0)

  `RCFD_ASSERT_IMPLY(a_slot2, clk_i, rst_ni, !empty_o && stub_count_o != 2'd3, stub2_position_o == 8'd0 && stub2_bend_o == 4'd0)

endmodule

bind readout_chip_frame_decoder rcfd_checker u_rcfd_checker (.*);

`default_nettype wire

// ===== verif/testbench.sv =====
// Self-checking testbench for readout_chip_frame_decoder: frame words go in through
// the push/full side, summaries are checked at the pop/empty side against a local decoder.
// Depends on rcfd_pkg and the decoder RTL.
`default_nettype none

module testbench;
  import rcfd_pkg::*;

  typedef struct packed {
    logic [31:0] word;
    logic        start;
    logic [2:0]  fe;
    logic [4:0]  chip;
  } frame_word_t;

  typedef struct packed {
    logic [7:0] hits;
    logic [1:0] stubs;
    logic [7:0] pos0;
    logic [3:0] bend0;
    logic [7:0] pos1;
    logic [3:0] bend1;
    logic [7:0] pos2;
    logic [3:0] bend2;
    logic [1:0] err;
    logic [8:0] pipe;
    logic [8:0] l1a;
    logic [4:0] flags;
  } summary_t;

  localparam logic [ADDR_W-1:0] EXP_BOARD_ADDR = ADDR_W'(4 * int'(REG_EXP_BOARD));
  localparam int DRAIN_CYCLES = 8;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;
  logic [31:0]       data_word = '0;
  logic              frame_start = 1'b0;
  logic [2:0]        fe_index = '0;
  logic [4:0]        chip_index = '0;
  logic              push = 1'b0;
  logic              full;
  logic              empty;
  logic              pop = 1'b0;
  logic [7:0]        hit_count;
  logic [1:0]        stub_count;
  logic [7:0]        stub0_position, stub1_position, stub2_position;
  logic [3:0]        stub0_bend, stub1_bend, stub2_bend;
  logic [1:0]        error_bits;
  logic [8:0]        pipeline_address;
  logic [8:0]        l1a_count;
  logic [4:0]        check_flags;

  readout_chip_frame_decoder uut (
    .clk_i              (clk),
    .rst_ni             (rst_n),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready),
    .data_word_i        (data_word),
    .frame_start_i      (frame_start),
    .fe_index_i         (fe_index),
    .chip_index_i       (chip_index),
    .push_i             (push),
    .full_o             (full),
    .empty_o            (empty),
    .pop_i              (pop),
    .hit_count_o        (hit_count),
    .stub_count_o       (stub_count),
    .stub0_position_o   (stub0_position),
    .stub0_bend_o       (stub0_bend),
    .stub1_position_o   (stub1_position),
    .stub1_bend_o       (stub1_bend),
    .stub2_position_o   (stub2_position),
    .stub2_bend_o       (stub2_bend),
    .error_bits_o       (error_bits),
    .pipeline_address_o (pipeline_address),
    .l1a_count_o        (l1a_count),
    .check_flags_o      (check_flags)
  );

  frame_word_t word_q[$];
  summary_t    summary_q[$];

  // local decoder state
  logic [4:0]  exp_board = '0;
  int unsigned dec_pos = 0;
  logic [7:0]  dec_hits = '0;
  logic [31:0] dec_stub_word = '0;
  logic [3:0]  dec_hdr_flags = '0;
  logic [31:0] dec_status = '0;

  int unsigned mismatches = 0;
  int unsigned words_taken = 0;
  int unsigned summaries_checked = 0;
  int unsigned board_settings = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
  end

  initial begin
    #5_000_000;
    $display("testbench: errors");
    $finish;
  end

  function automatic logic [8:0] reverse9(input logic [8:0] v);
    logic [8:0] r;
    for (int i = 0; i < 9; i++) r[i] = v[8 - i];
    return r;
  endfunction

  function automatic void decode_frame_word(input frame_word_t w);
    summary_t   s;
    logic [7:0] p [3];
    logic [3:0] b [3];
    int         n;
    words_taken++;
    if (w.start) dec_pos = 0;
    if (dec_pos >= FRAME_WORDS) return;
    if (dec_pos == 0) begin
      dec_hdr_flags = '0;
      if ({1'b0, w.word[24:20]} != {1'b0, exp_board} + 6'd1) dec_hdr_flags[0] = 1'b1;
      if ({1'b0, w.word[19:17]} != {1'b0, w.fe} + 4'd1) dec_hdr_flags[1] = 1'b1;
      if ({1'b0, w.word[16:12]} != {1'b0, w.chip} + 6'd1) dec_hdr_flags[2] = 1'b1;
      if (w.word[11:0] != DATA_SIZE) dec_hdr_flags[3] = 1'b1;
      dec_hits = '0;
    end else if (dec_pos == 1) begin
      dec_stub_word = w.word;
    end else if (dec_pos == 2) begin
      dec_status = w.word;
      dec_hits = dec_hits + 8'($countones(w.word & HIT_MASK_STATUS));
    end else if (dec_pos < FRAME_WORDS - 1) begin
      dec_hits = dec_hits + 8'($countones(w.word));
    end else begin
      dec_hits = dec_hits + 8'($countones(w.word & HIT_MASK_LAST));
    end
    dec_pos++;
    if (dec_pos != FRAME_WORDS) return;

    for (int k = 0; k < 3; k++) begin
      p[k] = '0;
      b[k] = '0;
    end
    n = 0;
    for (int k = 0; k < 3; k++) begin
      logic [7:0] sp;
      logic [3:0] sb;
      sp = dec_stub_word[8*k +: 8];
      sb = (k == 0) ? dec_stub_word[27:24] : (k == 1) ? dec_stub_word[31:28] : dec_status[3:0];
      if (sp != 0 && sb != 0) begin
        p[n] = sp;
        b[n] = sb;
        n++;
      end
    end
    s.hits  = dec_hits;
    s.stubs = 2'(n);
    s.pos0  = p[0];
    s.bend0 = b[0];
    s.pos1  = p[1];
    s.bend1 = b[1];
    s.pos2  = p[2];
    s.bend2 = b[2];
    s.err   = {dec_status[8], dec_status[9]};
    s.pipe  = reverse9(dec_status[18:10]);
    s.l1a   = reverse9(dec_status[27:19]);
    s.flags = {~dec_status[7], dec_hdr_flags};
    summary_q = {summary_q, s};
  endfunction

  function automatic void compare_field(input string name, input logic [31:0] exp_v,
                                        input logic [31:0] act_v);
    if (act_v !== exp_v) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch %s: expected %0h, got %0h", name, exp_v, act_v);
    end
  endfunction

  function automatic void check_summary();
    summary_t e;
    if (summary_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected summary beat, hits %0h", hit_count);
      return;
    end
    e = summary_q.pop_front();
    summaries_checked++;
    compare_field("hit_count", 32'(e.hits), 32'(hit_count));
    compare_field("stub_count", 32'(e.stubs), 32'(stub_count));
    compare_field("stub0_position", 32'(e.pos0), 32'(stub0_position));
    compare_field("stub0_bend", 32'(e.bend0), 32'(stub0_bend));
    compare_field("stub1_position", 32'(e.pos1), 32'(stub1_position));
    compare_field("stub1_bend", 32'(e.bend1), 32'(stub1_bend));
    compare_field("stub2_position", 32'(e.pos2), 32'(stub2_position));
    compare_field("stub2_bend", 32'(e.bend2), 32'(stub2_bend));
    compare_field("error_bits", 32'(e.err), 32'(error_bits));
    compare_field("pipeline_address", 32'(e.pipe), 32'(pipeline_address));
    compare_field("l1a_count", 32'(e.l1a), 32'(l1a_count));
    compare_field("check_flags", 32'(e.flags), 32'(check_flags));
  endfunction

  // driver: bursts with random gaps
  frame_word_t cur_word;
  int          gap_left = 0;
  int          burst_left = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      push <= 1'b0;
    end else begin
      if (push && !full) decode_frame_word(cur_word);
      if (!push || !full) begin
        if (gap_left > 0) begin
          gap_left = gap_left - 1;
          push <= 1'b0;
        end else if (word_q.size() != 0) begin
          cur_word = word_q.pop_front();
          data_word   <= cur_word.word;
          frame_start <= cur_word.start;
          fe_index    <= cur_word.fe;
          chip_index  <= cur_word.chip;
          push        <= 1'b1;
          if (burst_left > 0) begin
            burst_left = burst_left - 1;
          end else begin
            burst_left = $urandom_range(1, 50);
            case ($urandom_range(0, 9))
              0, 1, 2: gap_left = 0;
              3:       gap_left = $urandom_range(20, 60);
              default: gap_left = $urandom_range(1, 6);
            endcase
          end
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // monitor: pop follows its own run/stall pattern
  logic pop_state = 1'b0;
  int   pop_run = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) check_summary();
      if (pop_run > 0) begin
        pop_run = pop_run - 1;
      end else begin
        pop_state = ~pop_state;
        if (pop_state) begin
          pop_run = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 30);
        end else begin
          case ($urandom_range(0, 19))
            0:             pop_run = $urandom_range(40, 120);
            1, 2, 3, 4, 5: pop_run = $urandom_range(4, 15);
            default:       pop_run = $urandom_range(0, 3);
          endcase
        end
      end
      pop <= pop_state;
    end
  end

  task automatic wait_drained();
    do @(posedge clk); while (word_q.size() != 0 || push || summary_q.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_exp_board(input logic [4:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= EXP_BOARD_ADDR;
    pwdata  <= 32'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    exp_board = value;
    board_settings++;
  endtask

  function automatic void add_word(input logic [31:0] word, input logic start,
                                   input logic [2:0] fe, input logic [4:0] chip);
    frame_word_t w;
    w.word  = word;
    w.start = start;
    w.fe    = fe;
    w.chip  = chip;
    word_q = {word_q, w};
  endfunction

  function automatic void queue_frame(input int n_words, input logic start);
    logic [31:0] w;
    logic [2:0]  fe;
    logic [4:0]  chip;
    int          density;
    fe      = 3'($urandom);
    chip    = 5'($urandom);
    density = $urandom_range(0, 5);
    for (int i = 0; i < n_words; i++) begin
      w = $urandom;
      if (i == 0) begin
        if ($urandom_range(0, 4) != 0) w[24:20] = exp_board + 5'd1;
        if ($urandom_range(0, 4) != 0) w[19:17] = fe + 3'd1;
        if ($urandom_range(0, 4) != 0) w[16:12] = chip + 5'd1;
        if ($urandom_range(0, 4) != 0) w[11:0] = DATA_SIZE;
        add_word(w, start, fe, chip);
      end else begin
        if (i == 1) begin
          for (int k = 0; k < 3; k++)
            if ($urandom_range(0, 3) == 0) w[8*k +: 8] = '0;
          if ($urandom_range(0, 3) == 0) w[27:24] = '0;
          if ($urandom_range(0, 3) == 0) w[31:28] = '0;
        end else begin
          case (density)
            0:       w = '0;
            1:       w = '1;
            2:       w = $urandom & $urandom & $urandom;
            3:       w = $urandom | $urandom;
            default: w = $urandom;
          endcase
          if (i == 2) begin
            w[27:0] = 28'($urandom);
            if ($urandom_range(0, 3) == 0) w[3:0] = '0;
            w[7] = ($urandom_range(0, 5) != 0);
          end
        end
        add_word(w, ($urandom_range(0, 199) == 0), 3'($urandom), 5'($urandom));
      end
    end
  endfunction

  task automatic run_random(input int n_items);
    int sent;
    int n;
    bit paused;
    sent = 0;
    paused = 0;
    while (sent < n_items) begin
      if (!paused && sent > n_items / 2) begin
        wait_drained();
        paused = 1;
      end
      case ($urandom_range(0, 19))
        0, 1: begin
          n = $urandom_range(1, FRAME_WORDS - 1);
          queue_frame(n, 1'b1);
          sent += n;
        end
        2, 3: begin
          n = $urandom_range(1, 5);
          for (int i = 0; i < n; i++)
            add_word($urandom, ($urandom_range(0, 4) == 0), 3'($urandom), 5'($urandom));
        end
        4: queue_frame(FRAME_WORDS, 1'b0);
        default: begin
          queue_frame(FRAME_WORDS, 1'b1);
          sent += FRAME_WORDS;
        end
      endcase
      while (word_q.size() > 64) @(posedge clk);
    end
  endtask

  initial begin
    do @(posedge clk); while (!rst_n);
    write_exp_board(5'd0);

    // first frame right after reset without frame_start, fe and chip fields at their top
    add_word({7'h0, 5'd1, 3'd7, 5'd31, DATA_SIZE}, 1'b0, 3'd6, 5'd30);
    for (int i = 1; i < FRAME_WORDS; i++) add_word('1, 1'b0, 3'd0, 5'd0);
    // dropped partial frame, then a restart with every check failing
    add_word({7'h0, 5'd1, 3'd1, 5'd1, DATA_SIZE}, 1'b1, 3'd0, 5'd0);
    add_word('1, 1'b0, 3'd7, 5'd31);
    add_word('0, 1'b1, 3'd7, 5'd31);
    add_word(32'h0000_0101, 1'b0, 3'd0, 5'd0);
    for (int i = 2; i < FRAME_WORDS; i++) add_word('0, 1'b0, 3'd0, 5'd0);
    // word while idle is ignored
    add_word('1, 1'b0, 3'd7, 5'd31);
    wait_drained();

    write_exp_board(5'd30);
    run_random(500);
    wait_drained();
    write_exp_board(5'd31);
    run_random(400);
    wait_drained();
    write_exp_board(5'($urandom_range(1, 29)));
    run_random(550);
    wait_drained();
    write_exp_board(5'($urandom_range(0, 31)));
    run_random(550);
    wait_drained();

    if (summary_q.size() != 0) mismatches += summary_q.size();
    $display("covered %0d frame words, %0d summaries, %0d board id settings",
             words_taken, summaries_checked, board_settings);
    $display("mismatches seen: %0d", mismatches);
    if (mismatches == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

`default_nettype wire
